// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

// ===== hdl/lsp_pkg.sv =====
package lsp_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 15;
  localparam logic [CfgIdxW-1:0] RegCommand = 1'b0;
  localparam logic [CfgIdxW-1:0] RegNumLeds = 1'b1;

  localparam logic [14:0] MaxLeds = 15'd21845;
  localparam logic [15:0] ResetTotal = 16'd3;

  // Output step within one request: five header bytes then the colour byte
  localparam logic [2:0] StepZero  = 3'd0;
  localparam logic [2:0] StepCmd   = 3'd1;
  localparam logic [2:0] StepPosHi = 3'd2;
  localparam logic [2:0] StepPosLo = 3'd3;
  localparam logic [2:0] StepLen   = 3'd4;
  localparam logic [2:0] StepColor = 3'd5;

  // Job queue depth
  localparam int unsigned QDepth = 2;

  // One classified request, front to back
  typedef struct packed {
    logic        hdr;
    logic [15:0] pos;
    logic [7:0]  len;
    logic [7:0]  color;
    logic        fend;
  } job_t;

  // Colour translation by upper nibble
  function automatic logic [7:0] lsp_xlate(input logic [3:0] nib);
    logic [7:0] r;
    unique case (nib)
      4'h0: r = 8'h00;
      4'h1: r = 8'hc0;
      4'h2: r = 8'he0;
      4'h3: r = 8'h50;
      4'h4: r = 8'hf0;
      4'h5: r = 8'h04;
      4'h6: r = 8'h44;
      4'h7: r = 8'hcc;
      4'h8: r = 8'h22;
      4'h9: r = 8'h1a;
      4'ha: r = 8'h06;
      4'hb: r = 8'hc1;
      4'hc: r = 8'h05;
      4'hd: r = 8'h03;
      4'he: r = 8'hdd;
      4'hf: r = 8'hff;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/lsp_if.sv =====
// Colour byte channel
interface lsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_byte;

  modport source (output valid, output color_byte, input ready);
  modport sink   (input valid, input color_byte, output ready);
endinterface

// Serial byte channel
interface lsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_end;

  modport source (output valid, output out_byte, output last_of_run, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input frame_end,
                  output ready);
endinterface

// ===== hdl/lsp_queue.sv =====
module lsp_queue
  import lsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  job_t              mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      priority if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lsp_front.sv =====
module lsp_front
  import lsp_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsp_in_if.sink              in_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [7:0]          cmd_o,
  output logic                push_o,
  output job_t                job_o,
  input  logic                full_i
);

  logic [7:0]  cmd_q;
  logic [15:0] total_q;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  off_q, off_d;

  logic [14:0] leds_clamp;
  logic [15:0] total_new;
  logic        pos_wrap, fend;
  logic [15:0] pos_eff, pos_inc, remaining;
  logic [7:0]  off_eff;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign cmd_o      = cmd_q;

  // Strand length from a num_leds write
  always_comb begin
    if (cfg_data_i == '0) begin
      leds_clamp = 15'd1;
    end else if (cfg_data_i > MaxLeds) begin
      leds_clamp = MaxLeds;
    end else begin
      leds_clamp = cfg_data_i;
    end
    total_new = {leds_clamp, 1'b0} + {1'b0, leds_clamp};
  end

  // Classify the request against the current position
  always_comb begin
    pos_wrap  = (pos_q >= total_q);
    pos_eff   = pos_wrap ? '0 : pos_q;
    off_eff   = pos_wrap ? '0 : off_q;
    remaining = total_q - pos_eff;
    pos_inc   = pos_eff + 16'd1;
    fend      = (pos_inc == total_q);

    job_o.hdr   = (off_eff == '0);
    job_o.pos   = pos_eff;
    job_o.len   = (remaining >= 16'(PACKET_BYTES)) ? 8'd0 : remaining[7:0];
    job_o.color = lsp_xlate(in_i.color_byte[7:4]);
    job_o.fend  = fend;

    pos_d = fend ? '0 : pos_inc;
    priority if (fend || (off_eff == 8'(PACKET_BYTES - 1))) begin
      off_d = '0;
    end else begin
      off_d = off_eff + 8'd1;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= '0;
      total_q <= ResetTotal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCommand: cmd_q   <= cfg_data_i[7:0];
        RegNumLeds: total_q <= total_new;
      endcase
    end
  end

  // Byte position and offset within the packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      off_q <= '0;
    end else if (push_o) begin
      pos_q <= pos_d;
      off_q <= off_d;
    end
  end

endmodule

// ===== hdl/lsp_back.sv =====
module lsp_back
  import lsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [7:0] cmd_i,
  input  logic      empty_i,
  input  job_t      job_i,
  output logic      pop_o,
  lsp_out_if.source out_o
);

  job_t       cur_q;
  logic       cur_valid_q;
  logic [2:0] step_q;
  logic       fire, load;

  assign fire  = cur_valid_q && out_o.ready;
  assign load  = !cur_valid_q || (fire && (step_q == StepColor));
  assign pop_o = load && !empty_i;

  // Byte select for the current step
  always_comb begin
    unique case (step_q)
      StepZero:  out_o.out_byte = 8'h00;
      StepCmd:   out_o.out_byte = cmd_i;
      StepPosHi: out_o.out_byte = cur_q.pos[15:8];
      StepPosLo: out_o.out_byte = cur_q.pos[7:0];
      StepLen:   out_o.out_byte = cur_q.len;
      default:   out_o.out_byte = cur_q.color;
    endcase
  end

  assign out_o.valid       = cur_valid_q;
  assign out_o.last_of_run = (step_q == StepColor);
  assign out_o.frame_end   = (step_q == StepColor) && cur_q.fend;

  // Current job payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

  // Step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= StepColor;
    end else if (load) begin
      cur_valid_q <= !empty_i;
      step_q      <= job_i.hdr ? StepZero : StepColor;
    end else if (fire) begin
      step_q <= step_q + 3'd1;
    end
  end

endmodule

// ===== hdl/led_strand_packetizer_top.sv =====
// An accepted colour byte is written into the job queue and then loaded into the output
// sequencer's current-job register before its first output byte is valid. Throughput: one
// output byte per cycle while jobs are queued and the receiver is ready; a colour byte inside
// a packet is sent alone, one that opens a packet as five header bytes plus colour, as stepped
// by the output sequencer. A two-entry job queue lets input run ahead of the serial side.
// Reset (rst_ni low, async): position 0, queue empty, command 0, strand of one LED.
module led_strand_packetizer_top
  import lsp_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsp_in_if.sink              in_i,
  lsp_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic       push, pop, full, empty;
  logic [7:0] cmd;
  job_t       job_in, job_out;

  lsp_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_o     (cmd),
    .push_o    (push),
    .job_o     (job_in),
    .full_i    (full)
  );

  lsp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .job_o  (job_out)
  );

  lsp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .empty_i(empty),
    .job_i  (job_out),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ===== hdl/lsp_checker.sv =====
`include "assert_macros.svh"

module lsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       last_i,
  input logic       fend_i
);

  logic [2:0] run_cnt_q;

  // Count header bytes delivered since the last colour byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      run_cnt_q <= last_i ? 3'd0 : run_cnt_q + 3'd1;
    end
  end

  `ASSERT_ALWAYS(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `ASSERT_NEVER(a_fend_not_last, clk_i, rst_ni, out_valid_i && fend_i && !last_i)
  `ASSERT_ALWAYS(a_run_len, clk_i, rst_ni, out_valid_i && last_i |-> run_cnt_q == 3'd0 || run_cnt_q == 3'd5)
  `ASSERT_NEVER(a_hdr_overrun, clk_i, rst_ni, out_valid_i && !last_i && run_cnt_q == 3'd5)

endmodule

bind led_strand_packetizer_top lsp_checker u_lsp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .last_i     (out_o.last_of_run),
  .fend_i     (out_o.frame_end)
);

// ===== dv/tb.sv =====
module tb;
  import lsp_pkg::*;

  localparam int unsigned PktBytes  = 64;
  localparam int unsigned CycLimit  = 200000;
  localparam int unsigned HoldCycles = 120;

  // Serial byte as seen on the output channel
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
  } ser_byte_t;

  // Upper-nibble translation table of the serial protocol
  localparam logic [7:0] ColorLut [16] = '{
    8'h00, 8'hc0, 8'he0, 8'h50, 8'hf0, 8'h04, 8'h44, 8'hcc,
    8'h22, 8'h1a, 8'h06, 8'hc1, 8'h05, 8'h03, 8'hdd, 8'hff
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lsp_in_if  col_if ();
  lsp_out_if ser_if ();

  led_strand_packetizer_top #(
    .PACKET_BYTES(PktBytes)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (col_if),
    .out_o     (ser_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow of the block's registers and position
  logic [7:0]  cmd_shadow;
  logic [14:0] leds_shadow;
  logic [15:0] strand_pos;

  logic [7:0] color_q [$];
  ser_byte_t  serial_exp_q [$];

  int err_cnt;
  int cyc_cnt;
  int burst_left;
  int gap_left;
  int rx_cnt;
  int rx_mode;
  int hold_left;
  int hold_kick;
  int hold_seen;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected serial bytes for one colour request
  function automatic void packetize_byte(input logic [7:0] color);
    logic [14:0] leds;
    logic [16:0] total;
    logic [16:0] pos;
    logic [16:0] remain;
    logic [7:0]  len_byte;
    logic        fend;
    leds = leds_shadow;
    if (leds == 15'd0) leds = 15'd1;
    if (leds > MaxLeds) leds = MaxLeds;
    total = 17'(leds) * 17'd3;
    pos = {1'b0, strand_pos};
    // restart when a smaller strand left the position behind
    if (pos >= total) pos = '0;
    if ((pos % PktBytes) == 0) begin
      remain = total - pos;
      len_byte = (remain >= PktBytes) ? 8'd0 : remain[7:0];
      serial_exp_q.push_back('{8'h00, 1'b0, 1'b0});
      serial_exp_q.push_back('{cmd_shadow, 1'b0, 1'b0});
      serial_exp_q.push_back('{pos[15:8], 1'b0, 1'b0});
      serial_exp_q.push_back('{pos[7:0], 1'b0, 1'b0});
      serial_exp_q.push_back('{len_byte, 1'b0, 1'b0});
    end
    fend = (pos + 17'd1 == total);
    serial_exp_q.push_back('{ColorLut[color[7:4]], 1'b1, fend});
    strand_pos = fend ? 16'd0 : pos[15:0] + 16'd1;
  endfunction

  // Sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_if.valid      <= 1'b0;
      col_if.color_byte <= 8'h00;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (col_if.valid && col_if.ready) void'(color_q.pop_front());
      if (!col_if.valid || col_if.ready) begin
        if (gap_left > 0 || color_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          col_if.valid <= 1'b0;
        end else begin
          col_if.valid      <= 1'b1;
          col_if.color_byte <= color_q[0];
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // Input monitor: predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && col_if.valid && col_if.ready) packetize_byte(col_if.color_byte);
  end

  // Receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_if.ready <= 1'b0;
      rx_cnt    <= 0;
      rx_mode   <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      rx_cnt <= rx_cnt + 1;
      if (rx_cnt % 64 == 0) rx_mode <= $urandom_range(0, 3);
      if (hold_kick != hold_seen) begin
        hold_seen    <= hold_kick;
        hold_left    <= HoldCycles;
        ser_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        ser_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: begin
            ser_if.ready <= 1'b1;
          end
          1: begin
            ser_if.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            ser_if.ready <= ((rx_cnt % 8) < 5);
          end
          default: begin
            ser_if.ready <= 1'($urandom_range(0, 1));
          end
        endcase
      end
    end
  end

  // Output monitor: compare against the oldest expected byte
  always @(posedge clk_i) begin
    ser_byte_t exp_b;
    if (rst_ni && ser_if.valid && ser_if.ready) begin
      if (serial_exp_q.size() == 0) begin
        $error("unexpected serial byte %h", ser_if.out_byte);
        err_cnt++;
      end else begin
        exp_b = serial_exp_q.pop_front();
        if (ser_if.out_byte !== exp_b.out_byte) begin
          $error("out_byte: expected %h, got %h", exp_b.out_byte, ser_if.out_byte);
          err_cnt++;
        end
        if (ser_if.last_of_run !== exp_b.last_of_run) begin
          $error("last_of_run: expected %b, got %b", exp_b.last_of_run, ser_if.last_of_run);
          err_cnt++;
        end
        if (ser_if.frame_end !== exp_b.frame_end) begin
          $error("frame_end: expected %b, got %b", exp_b.frame_end, ser_if.frame_end);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CycLimit) begin
      $display("FAIL led_strand_packetizer_top");
      $finish;
    end
  end

  // Register write, shadowed at the edge that takes it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegCommand) cmd_shadow = val[7:0];
    else leds_shadow = val;
  endtask

  // Command write with junk in the unused upper bits, then a num_leds write
  task automatic set_strand(input logic [7:0] cmd, input logic [14:0] leds);
    logic [6:0] junk;
    junk = 7'($urandom_range(0, 127));
    write_reg(RegCommand, {junk, cmd});
    write_reg(RegNumLeds, leds);
  endtask

  // Wait until every request went through and the block is quiet
  task automatic settle();
    while (color_q.size() != 0 || col_if.valid || serial_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_random(input int cnt);
    repeat (cnt) color_q.push_back(8'($urandom_range(0, 255)));
    settle();
  endtask

  // Stimulus
  initial begin
    col_if.valid      = 1'b0;
    col_if.color_byte = 8'h00;
    ser_if.ready      = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = RegCommand;
    cfg_data_i = '0;
    err_cnt    = 0;
    cyc_cnt    = 0;
    hold_kick  = 0;
    cmd_shadow  = 8'h00;
    leds_shadow = 15'd1;
    strand_pos  = 16'd0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset strand: one LED, the three bytes form one short packet
    color_q.push_back(8'h00);
    color_q.push_back(8'hff);
    color_q.push_back(8'h80);
    settle();

    // zero LEDs behaves as one, all-ones command
    set_strand(8'hff, 15'd0);
    color_q.push_back(8'h7f);
    color_q.push_back(8'h01);
    color_q.push_back(8'hfe);
    settle();

    // every nibble of the lookup
    set_strand(8'h5a, 15'd22);
    for (int n = 0; n < 16; n++)
      color_q.push_back({4'(n), 4'($urandom_range(0, 15))});
    color_q.push_back(8'h0f);
    color_q.push_back(8'hf0);
    settle();

    // shorter strand forces a position restart
    set_strand(8'($urandom_range(0, 255)), 15'd2);
    send_random(6);

    // oversized strand saturates; long receiver hold-off fills the block
    set_strand(8'h00, 15'h7fff);
    hold_kick++;
    send_random(66);

    // largest legal strand
    set_strand(8'hff, MaxLeds);
    send_random(6);

    // short last packet and frame wrap
    set_strand(8'($urandom_range(0, 255)), 15'd22);
    send_random(68);

    repeat (2) begin
      set_strand(8'($urandom_range(0, 255)), 15'($urandom_range(0, 25)));
      send_random($urandom_range(5, 12));
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && serial_exp_q.size() == 0) begin
      $display("PASS led_strand_packetizer_top");
    end else begin
      $display("FAIL led_strand_packetizer_top");
    end
    $finish;
  end

endmodule
